@@ src/iirl_pkg.sv @@
package iirl_pkg;

  // defaults for the top level parameters
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int NUM_AXES_DEF     = 3;

  // fixed field and filter geometry
  localparam int AXIS_W     = 2;
  localparam int TAPS       = 4;
  localparam int NTERMS     = 2 * TAPS + 1;
  localparam int COEF_W     = 32;
  localparam int LO_W       = 16;
  localparam int FRAC_SHIFT = 28;

  // gravity preset of the z channel, Q15.16, and the bits it needs
  localparam int GRAVITY_Q16  = -642678;
  localparam int GRAVITY_BITS = 21;
  localparam int GRAVITY_AXIS = 2;

  // front queue depth
  localparam int QDEPTH = 2;

  // Q3.28 coefficients: b0..b4 on new and past inputs, then -a1..-a4 on past outputs
  localparam logic signed [COEF_W-1:0] COEFS [NTERMS] = '{
    32'sd508308,
    -32'sd595997,
    32'sd909746,
    -32'sd595997,
    32'sd508308,
    32'sd902548961,
    -32'sd1149603896,
    32'sd656261746,
    -32'sd141505722
  };

  // head of the front queue as seen by the back part
  typedef struct packed {
    logic              valid;
    logic              in_range;
    logic [AXIS_W-1:0] axis;
  } iirl_head_t;

endpackage

@@ src/iirl_if.sv @@
interface iirl_in_if #(
  parameter int SAMPLE_WIDTH = iirl_pkg::SAMPLE_WIDTH_DEF
);
  import iirl_pkg::*;

  logic                           valid;
  logic                           ready;
  logic [AXIS_W-1:0]              axis;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output axis, output sample, input ready);
  modport sink   (input valid, input axis, input sample, output ready);
endinterface

interface iirl_out_if #(
  parameter int SAMPLE_WIDTH = iirl_pkg::SAMPLE_WIDTH_DEF
);
  import iirl_pkg::*;

  logic                           valid;
  logic                           ready;
  logic [AXIS_W-1:0]              axis_out;
  logic signed [SAMPLE_WIDTH-1:0] filtered;

  modport source (output valid, output axis_out, output filtered, input ready);
  modport sink   (input valid, input axis_out, input filtered, output ready);
endinterface

@@ src/iirl_front.sv @@
module iirl_front #(
  parameter int SAMPLE_WIDTH = iirl_pkg::SAMPLE_WIDTH_DEF,
  parameter int NUM_AXES     = iirl_pkg::NUM_AXES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  iirl_in_if.sink                        in_i,
  output iirl_pkg::iirl_head_t           head_o,
  output logic signed [SAMPLE_WIDTH-1:0] head_sample_o,
  input  logic                           pop_i
);
  import iirl_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic signed [SAMPLE_WIDTH-1:0] sample_q [QDEPTH];
  logic [AXIS_W-1:0]              axis_q   [QDEPTH];
  logic                           range_q  [QDEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic push;
  logic pop;
  logic in_range;

  // classify: channel inside the configured set
  assign in_range = (32'(in_i.axis) < NUM_AXES);

  // queue handshake
  assign in_i.ready = (cnt_q != CNT_W'(QDEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      sample_q[wr_ptr_q] <= in_i.sample;
      axis_q[wr_ptr_q]   <= in_i.axis;
      range_q[wr_ptr_q]  <= in_range;
    end
  end

  // head of queue
  assign head_o.valid    = (cnt_q != '0);
  assign head_o.in_range = range_q[rd_ptr_q];
  assign head_o.axis     = axis_q[rd_ptr_q];
  assign head_sample_o   = sample_q[rd_ptr_q];

endmodule

@@ src/iirl_back.sv @@
module iirl_back #(
  parameter int SAMPLE_WIDTH = iirl_pkg::SAMPLE_WIDTH_DEF,
  parameter int NUM_AXES     = iirl_pkg::NUM_AXES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  iirl_pkg::iirl_head_t           head_i,
  input  logic signed [SAMPLE_WIDTH-1:0] head_sample_i,
  output logic                           pop_o,
  iirl_out_if.source                     out_o
);
  import iirl_pkg::*;

  localparam int AXI_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int HI_W  = SAMPLE_WIDTH - LO_W + 1;
  localparam int PH_W  = HI_W + COEF_W;
  localparam int PL_W  = LO_W + 1 + COEF_W;
  localparam int SH_W  = PH_W + 4;
  localparam int SL_W  = PL_W + 4;
  localparam int TOT_W = SH_W + LO_W + 1;

  localparam logic signed [SAMPLE_WIDTH-1:0] GRAV =
    (SAMPLE_WIDTH >= GRAVITY_BITS) ? SAMPLE_WIDTH'(GRAVITY_Q16)
                                   : {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [TOT_W-1:0] SMAX =
    {{(TOT_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [TOT_W-1:0] SMIN  = ~SMAX;
  localparam logic signed [TOT_W-1:0] ROUND = TOT_W'(1) <<< (FRAC_SHIFT - 1);

  // channel histories, newest first
  logic signed [SAMPLE_WIDTH-1:0] xh_q [NUM_AXES][TAPS];
  logic signed [SAMPLE_WIDTH-1:0] yh_q [NUM_AXES][TAPS];

  // issue
  logic             advance;
  logic             hazard;
  logic             issue;
  logic             upd;
  logic [AXI_W-1:0] head_idx;
  logic [AXI_W-1:0] rd_idx;

  // multiply stage
  logic signed [SAMPLE_WIDTH-1:0] ops    [NTERMS];
  logic signed [HI_W-1:0]         hi_op  [NTERMS];
  logic signed [LO_W:0]           lo_op  [NTERMS];
  logic signed [PH_W-1:0]         ph_d   [NTERMS];
  logic signed [PL_W-1:0]         pl_d   [NTERMS];
  logic signed [PH_W-1:0]         ph_q   [NTERMS];
  logic signed [PL_W-1:0]         pl_q   [NTERMS];
  logic                           s1_valid_q, s1_valid_d;
  logic                           s1_range_q;
  logic [AXIS_W-1:0]              s1_axis_q;
  logic [AXI_W-1:0]               s1_idx_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_q;

  // sum stage
  logic signed [SH_W-1:0]         sum_hi_d, sum_hi_q;
  logic signed [SL_W-1:0]         sum_lo_d, sum_lo_q;
  logic                           s2_valid_q;
  logic                           s2_range_q;
  logic [AXIS_W-1:0]              s2_axis_q;
  logic [AXI_W-1:0]               s2_idx_q;
  logic signed [SAMPLE_WIDTH-1:0] s2_sample_q;

  // round and saturate stage
  logic signed [TOT_W-1:0]        total;
  logic signed [TOT_W-1:0]        q_full;
  logic signed [SAMPLE_WIDTH-1:0] q_sat;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [AXIS_W-1:0]              out_axis_q;
  logic signed [SAMPLE_WIDTH-1:0] out_filt_q;

  // whole pipeline moves when the output register is free or being taken
  assign advance = !out_valid_q || out_o.ready;

  // hold a request whose channel still has a result in flight
  assign head_idx = AXI_W'(head_i.axis);
  assign rd_idx   = head_i.in_range ? head_idx : '0;
  assign hazard   = head_i.in_range &&
                    ((s1_valid_q && s1_range_q && (s1_idx_q == head_idx)) ||
                     (s2_valid_q && s2_range_q && (s2_idx_q == head_idx)));
  assign issue    = advance && head_i.valid && !hazard;
  assign pop_o    = issue;

  // operand select, split into signed high and unsigned low halves, and multiply
  always_comb begin
    ops[0] = head_sample_i;
    for (int k = 0; k < TAPS; k++) begin
      ops[1 + k]        = xh_q[rd_idx][k];
      ops[1 + TAPS + k] = yh_q[rd_idx][k];
    end
    for (int t = 0; t < NTERMS; t++) begin
      hi_op[t] = HI_W'(ops[t] >>> LO_W);
      lo_op[t] = $signed({1'b0, ops[t][LO_W-1:0]});
      ph_d[t]  = PH_W'(hi_op[t]) * PH_W'(COEFS[t]);
      pl_d[t]  = PL_W'(lo_op[t]) * PL_W'(COEFS[t]);
    end
  end

  // partial product sums
  always_comb begin
    sum_hi_d = '0;
    sum_lo_d = '0;
    for (int t = 0; t < NTERMS; t++) begin
      sum_hi_d = sum_hi_d + SH_W'(ph_q[t]);
      sum_lo_d = sum_lo_d + SL_W'(pl_q[t]);
    end
  end

  // recombine, round half up, saturate
  always_comb begin
    total  = (TOT_W'(sum_hi_q) <<< LO_W) + TOT_W'(sum_lo_q) + ROUND;
    q_full = total >>> FRAC_SHIFT;
    if (q_full > SMAX) begin
      q_sat = SAMPLE_WIDTH'(SMAX);
    end else if (q_full < SMIN) begin
      q_sat = SAMPLE_WIDTH'(SMIN);
    end else begin
      q_sat = SAMPLE_WIDTH'(q_full);
    end
  end

  assign s1_valid_d  = advance ? issue : s1_valid_q;
  assign out_valid_d = advance ? s2_valid_q : out_valid_q;
  assign upd         = advance && s2_valid_q && s2_range_q;

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      if (advance) begin
        s2_valid_q <= s1_valid_q;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ph_q        <= ph_d;
      pl_q        <= pl_d;
      s1_range_q  <= head_i.in_range;
      s1_axis_q   <= head_i.axis;
      s1_idx_q    <= rd_idx;
      s1_sample_q <= head_sample_i;
      sum_hi_q    <= sum_hi_d;
      sum_lo_q    <= sum_lo_d;
      s2_range_q  <= s1_range_q;
      s2_axis_q   <= s1_axis_q;
      s2_idx_q    <= s1_idx_q;
      s2_sample_q <= s1_sample_q;
      out_axis_q  <= s2_axis_q;
      out_filt_q  <= s2_range_q ? q_sat : '0;
    end
  end

  // history shift on result write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int k = 0; k < TAPS; k++) begin
          xh_q[a][k] <= (a == GRAVITY_AXIS) ? GRAV : '0;
          yh_q[a][k] <= (a == GRAVITY_AXIS) ? GRAV : '0;
        end
      end
    end else if (upd) begin
      for (int k = TAPS - 1; k > 0; k--) begin
        xh_q[s2_idx_q][k] <= xh_q[s2_idx_q][k - 1];
        yh_q[s2_idx_q][k] <= yh_q[s2_idx_q][k - 1];
      end
      xh_q[s2_idx_q][0] <= s2_sample_q;
      yh_q[s2_idx_q][0] <= q_sat;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.axis_out = out_axis_q;
  assign out_o.filtered = out_filt_q;

endmodule

@@ src/three_axis_fourth_order_iir_lowpass_top.sv @@
// channel | dir | payload                      | handshake
// in_i    | in  | axis[1:0], sample[SW-1:0]    | valid/ready, taken when both high
// out_o   | out | axis_out[1:0], filtered[SW] | valid/ready, taken when both high
//
// a request is queued on acceptance and its result passes the multiply stage and
// the sum stage to the output register; one request enters the filter pipeline
// each cycle unless the output stalls or a channel hazard holds it. a request for
// the same channel as one of the two before it waits until that result is written
// back to the channel history, so requests of one channel never overlap.
// reset loads the histories at once (x and y zero, z the gravity preset).
// a stalled output holds the whole pipeline; the two-entry queue keeps taking
// requests until full.
module three_axis_fourth_order_iir_lowpass_top #(
  parameter int NUM_AXES     = iirl_pkg::NUM_AXES_DEF,
  parameter int SAMPLE_WIDTH = iirl_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iirl_in_if.sink    in_i,
  iirl_out_if.source out_o
);
  import iirl_pkg::*;

  iirl_head_t                     head;
  logic signed [SAMPLE_WIDTH-1:0] head_sample;
  logic                           pop;

  // accept and classify, queue
  iirl_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .NUM_AXES    (NUM_AXES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .head_o       (head),
    .head_sample_o(head_sample),
    .pop_i        (pop)
  );

  // filter pipeline and histories
  iirl_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .NUM_AXES    (NUM_AXES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_sample_i(head_sample),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

@@ src/iirl_checker.sv @@
module iirl_checker #(
  parameter int SAMPLE_WIDTH = iirl_pkg::SAMPLE_WIDTH_DEF,
  parameter int NUM_AXES     = iirl_pkg::NUM_AXES_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [iirl_pkg::AXIS_W-1:0]    out_axis_i,
  input logic signed [SAMPLE_WIDTH-1:0] out_filtered_i
);
  import iirl_pkg::*;

  // queue plus three pipeline stages
  localparam int CAP   = QDEPTH + 3;
  localparam int CNT_W = $clog2(CAP + 2);

  logic [CNT_W-1:0] cnt_q, cnt_d;

  // requests in flight
  always_comb begin
    cnt_d = cnt_q;
    if (in_valid_i && in_ready_i) begin
      cnt_d = cnt_d + 1'b1;
    end
    if (out_valid_i && out_ready_i) begin
      cnt_d = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_axis_i) && $stable(out_filtered_i))
    else $error("stalled result changed");

  // unknown channel gives zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (32'(out_axis_i) >= NUM_AXES) |-> (out_filtered_i == '0))
    else $error("unknown channel with nonzero result");

  // no more requests in flight than storage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAP))
    else $error("requests in flight exceed capacity");

  // empty block takes requests and shows no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> in_ready_i && !out_valid_i)
    else $error("empty block stalled or invented a result");

endmodule

bind three_axis_fourth_order_iir_lowpass_top iirl_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH),
  .NUM_AXES    (NUM_AXES)
) u_iirl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_axis_i    (out_o.axis_out),
  .out_filtered_i(out_o.filtered)
);
